/* hw/rtl/hetp_pkg.sv */
// Shared types, constants and the exponent table generator for the Hawkes
// intensity tracker. No dependencies; every file but the checker refers to it by scope.
package hetp_pkg;

    localparam int DEFAULT_EXP_TABLE_ADDR_BITS = 8;
    localparam int MIN_EXP_TABLE_ADDR_BITS     = 4;
    localparam int MAX_EXP_TABLE_ADDR_BITS     = 12;

    localparam int unsigned LOG2E_Q16 = 94548;
    localparam int unsigned LN2_Q30   = 744261118;
    localparam int          SERIES_TERMS = 16;

    localparam logic [23:0] DECAY_RATE_RESET = 24'd65536;

    localparam int CFG_INDEX_BITS = 2;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    localparam cfg_index_t CFG_BASELINE_RATE = 2'd0;
    localparam cfg_index_t CFG_JUMP_GAIN     = 2'd1;
    localparam cfg_index_t CFG_DECAY_RATE    = 2'd2;

    // Operand selection for the shared multiplier.
    typedef logic [1:0] mul_sel_t;
    localparam mul_sel_t MUL_SCALE = 2'd0;  // beta * dt
    localparam mul_sel_t MUL_LOG2E = 2'd1;  // x * log2(e)
    localparam mul_sel_t MUL_FADE  = 2'd2;  // |excitation| * table entry
    localparam mul_sel_t MUL_JUMP  = 2'd3;  // alpha * |mark|

    typedef struct packed {
        logic     load_item;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     cap_exp;
        logic     cap_fade;
        logic     commit;
    } cmd_t;

    // Entry idx of a table of 2^-(idx/2^addr_bits) in unsigned Q1.16, built as
    // e^-z with a truncated alternating series in Q1.30. Used at elaboration.
    function automatic logic [16:0] exp_entry(input int unsigned idx,
                                              input int unsigned addr_bits);
        logic [63:0] z;
        logic [63:0] term;
        longint      sum;
        int          k;
        z    = (64'(idx) * 64'(LN2_Q30)) >> addr_bits;
        term = 64'd1 << 30;
        sum  = longint'(term);
        for (k = 1; k < SERIES_TERMS; k++)
        begin
            term = ((term * z) >> 30) / 64'(k);
            if ((k % 2) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > (longint'(1) << 30))
            sum = longint'(1) << 30;
        return 17'(sum >>> 14);
    endfunction

endpackage

/* hw/rtl/hetp_if.sv */
// Handshake channel interfaces for the Hawkes intensity tracker: input items,
// results and configuration writes. No dependencies beyond the package.
interface hetp_item_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [31:0]        time_step;
    logic signed [31:0] mark;

    modport source (output valid, kind, time_step, mark, input ready);
    modport sink   (input valid, kind, time_step, mark, output ready);
endinterface

interface hetp_result_if;
    logic               valid;
    logic               ready;
    logic [31:0]        intensity_before;
    logic [31:0]        intensity_after;
    logic signed [31:0] excitation_level;

    modport source (output valid, intensity_before, intensity_after, excitation_level,
                    input ready);
    modport sink   (input valid, intensity_before, intensity_after, excitation_level,
                    output ready);
endinterface

interface hetp_cfg_if;
    logic                      valid;
    logic                      ready;
    hetp_pkg::cfg_index_t      index;
    logic [31:0]               data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/hetp_exp_rom.sv */
// Constant table of 2^-f for the fractional part of the decay exponent,
// with a registered read. Depends on hetp_pkg for the entry generator.
module hetp_exp_rom #(
    parameter int EXP_TABLE_ADDR_BITS = hetp_pkg::DEFAULT_EXP_TABLE_ADDR_BITS
) (
    input  logic                           clk,
    input  logic [EXP_TABLE_ADDR_BITS-1:0] addr,
    output logic [16:0]                    entry
);

    localparam int DEPTH = 1 << EXP_TABLE_ADDR_BITS;

    logic [16:0] rom_w [DEPTH];
    logic [16:0] entry_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_entry
        localparam logic [16:0] VALUE =
            hetp_pkg::exp_entry(i, EXP_TABLE_ADDR_BITS);
        assign rom_w[i] = VALUE;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= rom_w[addr];
    end

    assign entry = entry_reg;

endmodule

/* hw/rtl/hetp_ctrl.sv */
// Sequencing state machine for the Hawkes intensity tracker: steps one item
// through the shared multiplier and owns the result valid flag. Uses hetp_pkg.
module hetp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output hetp_pkg::cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCALE = 3'd1;
    localparam logic [2:0] S_LOG   = 3'd2;
    localparam logic [2:0] S_LOOK  = 3'd3;
    localparam logic [2:0] S_FADE  = 3'd4;
    localparam logic [2:0] S_DECAY = 3'd5;
    localparam logic [2:0] S_JUMP  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_SCALE;
                end
            end
            S_SCALE:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = hetp_pkg::MUL_SCALE;
                state_next  = S_LOG;
            end
            S_LOG:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = hetp_pkg::MUL_LOG2E;
                state_next  = S_LOOK;
            end
            S_LOOK:
            begin
                cmd.cap_exp = 1'b1;
                state_next  = S_FADE;
            end
            S_FADE:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = hetp_pkg::MUL_FADE;
                state_next  = S_DECAY;
            end
            S_DECAY:
            begin
                cmd.cap_fade = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = hetp_pkg::MUL_JUMP;
                state_next   = S_JUMP;
            end
            S_JUMP:
            begin
                // The result register is free, or its transfer happens now.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* hw/rtl/hetp_datapath.sv */
// Datapath of the Hawkes intensity tracker: configuration registers, the
// shared multiplier, decay, jump and saturation. Uses hetp_pkg and hetp_exp_rom.
module hetp_datapath #(
    parameter int EXP_TABLE_ADDR_BITS = hetp_pkg::DEFAULT_EXP_TABLE_ADDR_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hetp_pkg::cmd_t       cmd,
    input  logic                 cfg_we,
    input  hetp_pkg::cfg_index_t cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 in_kind,
    input  logic [31:0]          in_time_step,
    input  logic signed [31:0]   in_mark,
    output logic [31:0]          out_before,
    output logic [31:0]          out_after,
    output logic signed [31:0]   out_exc
);

    logic [31:0]        baseline_reg;
    logic [23:0]        gain_reg;
    logic [23:0]        decay_reg;
    logic signed [31:0] exc_reg;

    logic               kind_reg;
    logic [31:0]        dt_reg;
    logic signed [31:0] mark_reg;

    logic [60:0]        prod_reg;
    logic               x_big_reg;
    logic               kill_reg;
    logic [4:0]         shift_reg;
    logic signed [31:0] dec_reg;
    logic [31:0]        before_reg;

    logic [31:0]        out_before_reg;
    logic [31:0]        out_after_reg;
    logic signed [31:0] out_exc_reg;

    logic [36:0]        mul_a;
    logic [23:0]        mul_b;
    logic [31:0]        exc_mag;
    logic [31:0]        mark_mag;
    logic [16:0]        rom_entry;
    logic [31:0]        fade_mag;
    logic signed [31:0] dec_value;
    logic signed [41:0] gain_value;
    logic signed [41:0] jump_sum;
    logic signed [31:0] exc_new;

    function automatic logic [31:0] rate_of(input logic [31:0] mu,
                                            input logic signed [31:0] exc);
        logic signed [33:0] lam;
        lam = $signed({2'b00, mu}) + 34'(exc);
        if (lam < 0)
            return 32'd0;
        else if (lam[32])
            return 32'hFFFF_FFFF;
        else
            return lam[31:0];
    endfunction

    assign exc_mag  = exc_reg[31]  ? 32'(-exc_reg)  : 32'(exc_reg);
    assign mark_mag = mark_reg[31] ? 32'(-mark_reg) : 32'(mark_reg);

    always_comb
    begin
        case (cmd.mul_sel)
            hetp_pkg::MUL_SCALE:
            begin
                mul_a = {5'b0, dt_reg};
                mul_b = decay_reg;
            end
            hetp_pkg::MUL_LOG2E:
            begin
                // x = (beta*dt) >> 16; upper bits of x are caught by x_big_reg.
                mul_a = prod_reg[52:16];
                mul_b = 24'(hetp_pkg::LOG2E_Q16);
            end
            hetp_pkg::MUL_FADE:
            begin
                mul_a = {5'b0, exc_mag};
                mul_b = {7'b0, rom_entry};
            end
            hetp_pkg::MUL_JUMP:
            begin
                mul_a = {5'b0, mark_mag};
                mul_b = gain_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    hetp_exp_rom #(
        .EXP_TABLE_ADDR_BITS(EXP_TABLE_ADDR_BITS)
    ) u_exp_rom (
        .clk   (clk),
        .addr  (prod_reg[31 -: EXP_TABLE_ADDR_BITS]),
        .entry (rom_entry)
    );

    // Decayed magnitude: (|exc| * entry) >> (16 + n).
    assign fade_mag = prod_reg[47:16] >> shift_reg;

    always_comb
    begin
        if (dt_reg == 32'd0)
            dec_value = exc_reg;
        else if (kill_reg)
            dec_value = '0;
        else if (exc_reg[31])
            dec_value = $signed(32'(-fade_mag));
        else
            dec_value = $signed(fade_mag);
    end

    assign gain_value = mark_reg[31] ? -$signed({2'b00, prod_reg[55:16]})
                                     :  $signed({2'b00, prod_reg[55:16]});
    assign jump_sum   = 42'(dec_reg) + gain_value;

    always_comb
    begin
        if (!kind_reg)
            exc_new = dec_reg;
        else if (jump_sum > 42'sd2147483647)
            exc_new = 32'sh7FFF_FFFF;
        else if (jump_sum < -42'sd2147483648)
            exc_new = 32'sh8000_0000;
        else
            exc_new = jump_sum[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg <= '0;
            gain_reg     <= '0;
            decay_reg    <= hetp_pkg::DECAY_RATE_RESET;
            exc_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    hetp_pkg::CFG_BASELINE_RATE: baseline_reg <= cfg_data;
                    hetp_pkg::CFG_JUMP_GAIN:     gain_reg     <= cfg_data[23:0];
                    hetp_pkg::CFG_DECAY_RATE:    decay_reg    <= cfg_data[23:0];
                    default:                     ;
                endcase
            end
            if (cmd.commit)
                exc_reg <= exc_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg <= in_kind;
            dt_reg   <= in_time_step;
            mark_reg <= in_mark;
        end
        if (cmd.mul_en)
            prod_reg <= {24'b0, mul_a} * {37'b0, mul_b};
        if (cmd.mul_en && (cmd.mul_sel == hetp_pkg::MUL_LOG2E))
            x_big_reg <= |prod_reg[60:53];
        if (cmd.cap_exp)
        begin
            // Integer part of the base-2 exponent at 32 or more clears the value.
            kill_reg  <= x_big_reg | (|prod_reg[60:37]);
            shift_reg <= prod_reg[36:32];
        end
        if (cmd.cap_fade)
        begin
            dec_reg    <= dec_value;
            before_reg <= rate_of(baseline_reg, dec_value);
        end
        if (cmd.commit)
        begin
            out_before_reg <= before_reg;
            out_after_reg  <= rate_of(baseline_reg, exc_new);
            out_exc_reg    <= exc_new;
        end
    end

    assign out_before = out_before_reg;
    assign out_after  = out_after_reg;
    assign out_exc    = out_exc_reg;

endmodule

/* hw/rtl/hawkes_exp_intensity_tracker_top.sv */
// Sequence: after the input transfer the item steps through the scale, log, look,
// fade, decay and jump states; the jump state commits the result and sets its valid flag.
// A new item is taken only in idle, after the last one is through; the shared 37x24 multiplier is used four
// times in sequence (time scaling, base change, fade, jump) around one table read.
// A waiting result does not block the next input transfer until its commit cycle.
// Reset clears the excitation and restores the register defaults at once.
module hawkes_exp_intensity_tracker_top #(
    parameter int EXP_TABLE_ADDR_BITS = hetp_pkg::DEFAULT_EXP_TABLE_ADDR_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    hetp_item_if.sink   item,
    hetp_result_if.source result,
    hetp_cfg_if.sink    cfg
);

    hetp_pkg::cmd_t cmd;

    assign cfg.ready = 1'b1;

    hetp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    hetp_datapath #(
        .EXP_TABLE_ADDR_BITS(EXP_TABLE_ADDR_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .in_kind      (item.kind),
        .in_time_step (item.time_step),
        .in_mark      (item.mark),
        .out_before   (result.intensity_before),
        .out_after    (result.intensity_after),
        .out_exc      (result.excitation_level)
    );

endmodule

/* hw/rtl/hetp_checker.sv */
// Port-level checks for the Hawkes intensity tracker, attached by bind.
// Depends only on the top level's ports.
module hetp_checker (
    input logic clk,
    input logic rst_n,
    input logic item_valid,
    input logic item_ready,
    input logic result_valid,
    input logic result_ready
);

    // A waiting result stays offered until its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result withdrawn before transfer");

    // One item at a time: no input transfer straight after another.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("input taken while an item is in progress");

    // A fresh result always belongs to the item taken before the scale, log, look, fade, decay and jump states.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready, 7))
        else $error("result without a matching input transfer");

endmodule

bind hawkes_exp_intensity_tracker_top hetp_checker u_hetp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready)
);
